// File: design/stp_pkg.sv
// ----------------------------------------------------------------------------
// stp_pkg
// Shared types and constants for the stride table prefetcher.
// ----------------------------------------------------------------------------
package stp_pkg;

  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned STAMP_W = 31;
  localparam int unsigned LINE_W  = 13;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned PADDR_W = 3;

  localparam logic [STAMP_W-1:0] STAMP_MAX        = {STAMP_W{1'b1}};
  localparam logic [LINE_W-1:0]  LINE_BYTES_RESET = LINE_W'(64);

  // register word index (paddr[2])
  localparam logic REG_LINE_BYTES = 1'b0;

  // one table entry as stored in the ram
  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [ADDR_W-1:0]  stride;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic clear_wr;  // write a zero entry at the sweep index
    logic start;     // transaction accepted, latch address
    logic rd_en;     // read the entry at the sweep index
    logic calc;      // form stride, match and new stamp
    logic commit;    // write back the entry and load the result
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_stall;  // result register full and not taken
  } status_t;

endpackage

// File: design/stride_table_prefetcher_core.sv
// ----------------------------------------------------------------------------
// stride_table_prefetcher_core
// Stride prefetcher on a reference prediction table, one access per
// transaction, one result per transaction.
// ----------------------------------------------------------------------------
// Each accepted access address is looked up in a table of TABLE_ENTRIES
// entries (address, signed stride, insertion stamp) held in one ram with a
// single read port. The controller reads one entry per cycle, so a
// transaction runs from acceptance through TABLE_ENTRIES scan reads, a
// drain state for the last read data, a state to form the stride and a
// write-back state that also loads the result register, then back to
// idle, where the next transaction is taken; no access is taken while
// one is in progress. The single ram read port sets this pace. After
// reset the table is swept to zero, one entry per cycle, and in_ready
// stays low until the sweep ends, while the
// configuration port works from the first cycle. A miss replaces the first
// oldest entry and never prefetches; a hit stores the new stride and asks
// for address + line_bytes when the stride repeats the newest entry's one.
// The result waits in an output register, so the next access is taken
// while an earlier result is still held; the write-back of that next access
// waits for as long as the register stays full.
// ----------------------------------------------------------------------------
module stride_table_prefetcher_core #(
  parameter int unsigned TABLE_ENTRIES = 128
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // access channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [stp_pkg::ADDR_W-1:0]   in_access_address,
  // prefetch channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_prefetch_valid,
  output logic [stp_pkg::ADDR_W-1:0]   out_prefetch_address,
  // apb register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [stp_pkg::PADDR_W-1:0]  paddr,
  input  logic [stp_pkg::DATA_W-1:0]   pwdata,
  output logic [stp_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import stp_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_ENTRIES);

  cmd_t          cmd;
  status_t       status;
  logic [IW-1:0] idx;

  logic [LINE_W-1:0] line_bytes_r;
  logic              reg_sel;

  // word index of the register: paddr[2], low bits are byte lanes
  assign reg_sel = (paddr[2] == REG_LINE_BYTES);

  // line size register, written on the access phase of a write transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_bytes_r <= LINE_BYTES_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      line_bytes_r <= pwdata[LINE_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = reg_sel ? DATA_W'(line_bytes_r) : '0;

  // sequencer
  stp_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd),
    .idx      (idx)
  );

  // table, scan and result
  stp_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .idx                  (idx),
    .status               (status),
    .in_access_address    (in_access_address),
    .line_bytes           (line_bytes_r),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_prefetch_valid   (out_prefetch_valid),
    .out_prefetch_address (out_prefetch_address)
  );

  // a transaction blocks the input until its write-back is done
  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready
  ) else $error("input accepted again during a table scan");

  // a new result only appears after a write-back
  a_result_after_scan: assert property (
    @(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready)
  ) else $error("result raised outside the write-back cycle");

  // no prefetch means a zero address
  a_no_prefetch_zero: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_valid && !out_prefetch_valid |-> out_prefetch_address == '0
  ) else $error("prefetch address not zero without a prefetch");

endmodule

// File: design/stp_ram.sv
// ----------------------------------------------------------------------------
// stp_ram
// Generic single write port, single read port ram with registered read.
// ----------------------------------------------------------------------------
module stp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/stp_ctrl.sv
// ----------------------------------------------------------------------------
// stp_ctrl
// Sequencer: clearing sweep after reset, then one table scan per transaction.
// ----------------------------------------------------------------------------
module stp_ctrl #(
  parameter int unsigned TABLE_ENTRIES = 128
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  stp_pkg::status_t                 status,
  output stp_pkg::cmd_t                    cmd,
  output logic [$clog2(TABLE_ENTRIES)-1:0] idx
);
  import stp_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_ENTRIES);
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_CALC,
    S_WRITE
  } state_t;

  state_t        state_r;
  logic [IW-1:0] idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      idx_r   <= '0;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          idx_r <= idx_r + IW'(1);
          if (idx_r == LAST_IDX) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          idx_r <= '0;
          if (in_valid) begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          idx_r <= idx_r + IW'(1);
          if (idx_r == LAST_IDX) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state_r <= S_CALC;
        end
        S_CALC: begin
          state_r <= S_WRITE;
        end
        S_WRITE: begin
          if (!status.out_stall) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.clear_wr = (state_r == S_CLEAR);
    cmd.start    = (state_r == S_IDLE) && in_valid;
    cmd.rd_en    = (state_r == S_SCAN);
    cmd.calc     = (state_r == S_CALC);
    cmd.commit   = (state_r == S_WRITE) && !status.out_stall;
  end

  assign in_ready = (state_r == S_IDLE);
  assign idx      = idx_r;

endmodule

// File: design/stp_dpath.sv
// ----------------------------------------------------------------------------
// stp_dpath
// Table ram, scan accumulators, stride compare and result register.
// ----------------------------------------------------------------------------
module stp_dpath #(
  parameter int unsigned TABLE_ENTRIES = 128
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  stp_pkg::cmd_t                    cmd,
  input  logic [$clog2(TABLE_ENTRIES)-1:0] idx,
  output stp_pkg::status_t                 status,
  input  logic [stp_pkg::ADDR_W-1:0]       in_access_address,
  input  logic [stp_pkg::LINE_W-1:0]       line_bytes,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_prefetch_valid,
  output logic [stp_pkg::ADDR_W-1:0]       out_prefetch_address
);
  import stp_pkg::*;

  localparam int unsigned IW = $clog2(TABLE_ENTRIES);

  // ram ports
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  entry_t        ram_wdata;
  entry_t        ram_rdata;

  // scan state
  logic          eval_r;
  logic [IW-1:0] eval_idx_r;
  logic [ADDR_W-1:0]  addr_r;
  logic               found_r;
  logic [IW-1:0]      hit_idx_r;
  logic [STAMP_W-1:0] hit_stamp_r;
  logic [STAMP_W-1:0] max_stamp_r;
  logic [ADDR_W-1:0]  new_addr_r;
  logic [ADDR_W-1:0]  new_stride_r;
  logic [STAMP_W-1:0] min_stamp_r;
  logic [IW-1:0]      old_idx_r;

  // calc results
  logic [ADDR_W-1:0]  stride_r;
  logic               match_r;
  logic [ADDR_W-1:0]  sum_r;
  logic [STAMP_W-1:0] ins_stamp_r;
  logic [ADDR_W-1:0]  stride_nxt;

  // result register
  logic               out_valid_r;
  logic               out_pv_r;
  logic [ADDR_W-1:0]  out_pa_r;

  logic first_entry;

  stp_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  always_comb begin
    ram_we    = cmd.clear_wr | cmd.commit;
    ram_waddr = cmd.clear_wr ? idx : (found_r ? hit_idx_r : old_idx_r);
    ram_wdata = '0;
    if (!cmd.clear_wr) begin
      ram_wdata.addr   = addr_r;
      ram_wdata.stride = stride_r;
      ram_wdata.stamp  = found_r ? hit_stamp_r : ins_stamp_r;
    end
  end

  assign first_entry = (eval_idx_r == '0);
  assign stride_nxt  = addr_r - new_addr_r;

  // read data lands in the cycle after the read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eval_r  <= 1'b0;
      found_r <= 1'b0;
    end else begin
      eval_r <= cmd.rd_en;
      if (cmd.start) begin
        found_r <= 1'b0;
      end else if (eval_r && !found_r && ram_rdata.addr == addr_r) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    eval_idx_r <= idx;
    if (cmd.start) begin
      addr_r <= in_access_address;
    end
    if (eval_r) begin
      if (!found_r && ram_rdata.addr == addr_r) begin
        hit_idx_r   <= eval_idx_r;
        hit_stamp_r <= ram_rdata.stamp;
      end
      // first entry with the greatest stamp
      if (first_entry || ram_rdata.stamp > max_stamp_r) begin
        max_stamp_r  <= ram_rdata.stamp;
        new_addr_r   <= ram_rdata.addr;
        new_stride_r <= ram_rdata.stride;
      end
      // first entry with the smallest stamp
      if (first_entry || ram_rdata.stamp < min_stamp_r) begin
        min_stamp_r <= ram_rdata.stamp;
        old_idx_r   <= eval_idx_r;
      end
    end
    if (cmd.calc) begin
      stride_r    <= stride_nxt;
      match_r     <= found_r && (stride_nxt == new_stride_r);
      sum_r       <= addr_r + ADDR_W'(line_bytes);
      ins_stamp_r <= (max_stamp_r == STAMP_MAX) ? STAMP_MAX : max_stamp_r + STAMP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_pv_r <= match_r;
      out_pa_r <= match_r ? sum_r : '0;
    end
  end

  assign status.out_stall     = out_valid_r && !out_ready;
  assign out_valid            = out_valid_r;
  assign out_prefetch_valid   = out_pv_r;
  assign out_prefetch_address = out_pa_r;

endmodule

// File: tb/tb_stride_table_prefetcher_core.sv
// ----------------------------------------------------------------------------
// tb_stride_table_prefetcher_core
// Self-checking bench for the stride table prefetcher core: a scoreboard
// models the reference prediction table and the expected prefetch of each
// access, while plain tasks drive accesses and the register port under
// varied idling and back-pressure.
// ----------------------------------------------------------------------------
module tb_stride_table_prefetcher_core;
  import stp_pkg::*;

  localparam int unsigned ENTRIES          = 128;
  localparam int unsigned BLOCK_LATENCY    = ENTRIES + 4;
  localparam int unsigned HOLD_OFF_CYCLES  = 400;
  localparam int unsigned WATCHDOG_LIMIT   = 4000;
  localparam int unsigned RECENT_DEPTH     = 64;
  localparam logic [PADDR_W-1:0] LINE_BYTES_ADDR = {REG_LINE_BYTES, 2'b00};

  localparam logic [ADDR_W-1:0] EXTREMES [4] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF
  };

  // hand-picked opening accesses, run at the reset line size
  localparam logic [ADDR_W-1:0] DIRECTED [22] = '{
    32'h0000_0000,  // empty table: hits entry 0, which is also the newest
    32'h0000_0010,  // miss where oldest and newest are the same entry
    32'h0000_0000,  // ties: first zero-address entry is the hit
    32'hFFFF_FFF0,  // wrap pattern: target first
    32'hFFFF_FFD0,
    32'hFFFF_FFE0,
    32'hFFFF_FFF0,  // stride repeats, prefetch address wraps past 2^32
    32'hFFFF_FFF0,
    32'hFFFF_FFE0,  // hit on newest, stride 0 overwrites it
    32'hFFFF_FFE0,  // newest old stride now 0, so it repeats
    32'h0000_0F80,  // negative stride pattern
    32'h0000_1000,
    32'h0000_0FC0,
    32'h0000_0F80,
    32'h1234_5678,  // half-range stride equals its own negation
    32'h9234_5678,
    32'h1234_5678,
    32'hFFFF_FFFF,
    32'h8000_0000,
    32'h7FFF_FFFF,
    32'hAAAA_AAAA,
    32'h5555_5555
  };

  // --------------------------------------------------------------------------
  // prediction table model and store of expected prefetch results
  // --------------------------------------------------------------------------
  class stride_predictor;
    localparam int unsigned SLOTS = 128;

    typedef struct packed {
      logic              pf_valid;
      logic [ADDR_W-1:0] pf_addr;
    } prefetch_t;

    entry_t            rpt [SLOTS];
    logic [LINE_W-1:0] line_bytes;
    prefetch_t         pending_prefetch [$];
    int unsigned       errors;

    function new();
      foreach (rpt[i]) rpt[i] = '0;
      line_bytes = LINE_BYTES_RESET;
      errors     = 0;
    endfunction

    function void set_line_bytes(input logic [LINE_W-1:0] value);
      line_bytes = value;
    endfunction

    task flag_mismatch(input string msg);
      if (errors < 100) $display("mismatch: %s", msg);
      errors++;
    endtask

    // one full table scan per access, same order the hardware walks
    function void note_access(input logic [ADDR_W-1:0] a);
      bit                 found;
      int unsigned        hit_idx, newest_idx, oldest_idx;
      logic [STAMP_W-1:0] max_st, min_st;
      logic [ADDR_W-1:0]  stride, prior_stride;
      prefetch_t          res;
      found      = 1'b0;
      hit_idx    = 0;
      newest_idx = 0;
      oldest_idx = 0;
      max_st     = '0;
      min_st     = STAMP_MAX;
      for (int i = 0; i < SLOTS; i++) begin
        if (!found && rpt[i].addr == a) begin
          found   = 1'b1;
          hit_idx = i;
        end
        if (rpt[i].stamp > max_st) begin
          max_st     = rpt[i].stamp;
          newest_idx = i;
        end
        if (rpt[i].stamp < min_st) begin
          min_st     = rpt[i].stamp;
          oldest_idx = i;
        end
      end
      res    = '0;
      stride = a - rpt[newest_idx].addr;
      if (!found) begin
        rpt[oldest_idx].addr   = a;
        rpt[oldest_idx].stride = stride;
        rpt[oldest_idx].stamp  = (max_st >= STAMP_MAX) ? STAMP_MAX : max_st + 1'b1;
      end else begin
        // newest stride is read before the hit entry is written
        prior_stride        = rpt[newest_idx].stride;
        rpt[hit_idx].stride = stride;
        if (stride == prior_stride) begin
          res.pf_valid = 1'b1;
          res.pf_addr  = a + ADDR_W'(line_bytes);
        end
      end
      pending_prefetch.push_back(res);
    endfunction

    task check_prefetch(input logic pv, input logic [ADDR_W-1:0] pa);
      prefetch_t want;
      if (pending_prefetch.size() == 0) begin
        flag_mismatch($sformatf("result with no access pending (valid %0b addr %h)", pv, pa));
      end else begin
        want = pending_prefetch.pop_front();
        if (pv !== want.pf_valid)
          flag_mismatch($sformatf("prefetch_valid %0b, wanted %0b", pv, want.pf_valid));
        if (pa !== want.pf_addr)
          flag_mismatch($sformatf("prefetch_address %h, wanted %h", pa, want.pf_addr));
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block
  // --------------------------------------------------------------------------
  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [ADDR_W-1:0]   in_access_address;
  logic                out_valid;
  logic                out_ready;
  logic                out_prefetch_valid;
  logic [ADDR_W-1:0]   out_prefetch_address;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  stride_table_prefetcher_core #(
    .TABLE_ENTRIES (ENTRIES)
  ) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_access_address    (in_access_address),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_prefetch_valid   (out_prefetch_valid),
    .out_prefetch_address (out_prefetch_address),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  stride_predictor sb = new();

  // knobs shared between the stimulus and the receiver
  int unsigned       send_idle_pct  = 0;
  int unsigned       recv_stall_pct = 0;
  int unsigned       hold_off_asked = 0;
  int unsigned       items_sent     = 0;
  logic [ADDR_W-1:0] recent_addr [$];

  // --------------------------------------------------------------------------
  // monitor: results are checked before the access of the same edge is noted
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        sb.check_prefetch(out_prefetch_valid, out_prefetch_address);
      if (in_valid && in_ready)
        sb.note_access(in_access_address);
    end
  end

  // --------------------------------------------------------------------------
  // receiver: random stalls, plus long hold-offs on request
  // --------------------------------------------------------------------------
  initial begin : receiver
    int unsigned holds_served;
    holds_served = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_off_asked) begin
        // block fills while nothing drains the result register
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
        holds_served++;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog: too many cycles without any transaction ends the run
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("tb_stride_table_prefetcher_core: done, errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------
  // valid stays high across back-to-back transactions, dropped only for gaps
  task automatic send_access(input logic [ADDR_W-1:0] a);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_access_address <= a;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    recent_addr.push_back(a);
    if (recent_addr.size() > RECENT_DEPTH) void'(recent_addr.pop_front());
  endtask

  // sender pauses until every expected prefetch result is back
  task automatic wait_all_prefetches();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_prefetch.size() != 0) @(posedge clk);
  endtask

  task automatic write_line_bytes(input logic [DATA_W-1:0] word);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LINE_BYTES_ADDR;
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_line_bytes(word[LINE_W-1:0]);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_line_bytes_readback(input logic [LINE_W-1:0] want_val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= LINE_BYTES_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== DATA_W'(want_val))
      sb.flag_mismatch($sformatf("line_bytes read %h, wanted %h", prdata, want_val));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // target, base, base+step, then target again: the stride repeats on the hit
  task automatic send_stride_pattern();
    logic [ADDR_W-1:0] base, step, target;
    int unsigned       pick, repeats;
    pick = $urandom_range(9);
    if (pick == 0) begin
      step = '0;
    end else if (pick <= 5) begin
      step = $urandom_range(64, 1) * 64;
      if ($urandom_range(1)) step = -step;
    end else if (pick <= 7) begin
      step = $urandom_range(16, 1);
    end else begin
      step = $urandom;
    end
    base   = $urandom;
    target = base + 2 * step;
    send_access(target);
    send_access(base);
    // broken sequence: a stray access becomes the newest entry
    if ($urandom_range(4) == 0) send_access($urandom);
    send_access(base + step);
    repeats = $urandom_range(3, 1);
    repeat (repeats) send_access(target);
    // hit on the newest entry twice
    if ($urandom_range(3) == 0) begin
      send_access(base + step);
      send_access(base + step);
    end
  endtask

  task automatic send_random_items(input int unsigned count);
    int unsigned goal, pick;
    goal = items_sent + count;
    while (items_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 60)
        send_stride_pattern();
      else if (pick < 80 && recent_addr.size() != 0)
        send_access(recent_addr[$urandom_range(recent_addr.size() - 1)]);
      else if (pick < 90)
        send_access(EXTREMES[$urandom_range(3)]);
      else
        send_access($urandom);
    end
  endtask

  task automatic run_phase(input logic [DATA_W-1:0] line_word,
                           input int unsigned sidle, input int unsigned rstall,
                           input int unsigned count, input bit squeeze);
    wait_all_prefetches();
    write_line_bytes(line_word);
    check_line_bytes_readback(line_word[LINE_W-1:0]);
    send_idle_pct  = sidle;
    recv_stall_pct = rstall;
    if (squeeze) hold_off_asked++;
    send_random_items(count);
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_access_address <= '0;
    psel              <= 1'b0;
    penable           <= 1'b0;
    pwrite            <= 1'b0;
    paddr             <= '0;
    pwdata            <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // register port answers during the clearing sweep
    check_line_bytes_readback(LINE_BYTES_RESET);

    // directed part at the reset line size, no idling
    foreach (DIRECTED[i]) send_access(DIRECTED[i]);

    // smallest line, full rate
    run_phase(DATA_W'(1), 0, 0, 150, 1'b0);
    // 4096-byte line, sparse sender
    run_phase(DATA_W'(4096), 82, 0, 150, 1'b0);
    // zero line, slow receiver
    run_phase(DATA_W'(0), 0, 82, 150, 1'b0);
    // all-ones register with junk above the field, both sides idling
    run_phase(($urandom & ~DATA_W'(13'h1FFF)) | DATA_W'(13'h1FFF), 25, 25, 150, 1'b0);
    // long receiver hold-off while the sender keeps offering
    run_phase(DATA_W'($urandom_range(4096, 1)), 0, 0, 100, 1'b1);
    // random line, both sides idling
    run_phase(DATA_W'($urandom_range(4096, 1)), 25, 25, 130, 1'b0);

    wait_all_prefetches();
    repeat (BLOCK_LATENCY) @(posedge clk);
    if (sb.pending_prefetch.size() != 0)
      sb.flag_mismatch($sformatf("%0d prefetch results never came",
                                 sb.pending_prefetch.size()));

    if (sb.errors == 0)
      $display("tb_stride_table_prefetcher_core: done, clean");
    else
      $display("tb_stride_table_prefetcher_core: done, errors");
    $finish;
  end

endmodule

// File: filelist.f
design/stp_pkg.sv
design/stp_ram.sv
design/stp_ctrl.sv
design/stp_dpath.sv
design/stride_table_prefetcher_core.sv
tb/tb_stride_table_prefetcher_core.sv
